>>> design/ats_pkg.sv
// Package for the affine transform stack: widths, op and error codes, constants.
// No dependencies.
package ats_pkg;
   localparam int STACK_DEPTH = 16;
   localparam int FRAC_BITS   = 16;
   localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
   localparam int ENT_W       = $clog2(STACK_DEPTH);
   localparam int ADDR_W      = $clog2(STACK_DEPTH * 6);
   localparam logic signed [31:0] Q_ONE = 32'sd1 <<< FRAC_BITS;

   localparam logic [1:0] OP_ENTER = 2'd0;
   localparam logic [1:0] OP_EXIT  = 2'd1;
   localparam logic [1:0] OP_SET   = 2'd2;
   localparam logic [1:0] OP_MAP   = 2'd3;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_OVER  = 2'd1;
   localparam logic [1:0] ERR_UNDER = 2'd2;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] coef_a;
      logic signed [31:0] coef_b;
      logic signed [31:0] coef_c;
      logic signed [31:0] coef_d;
      logic signed [31:0] coef_e;
      logic signed [31:0] coef_f;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] mapped_x;
      logic signed [31:0] mapped_y;
      logic               point_valid;
      logic [1:0]         error_code;
   } rsp_type;

   function automatic logic signed [31:0] ident_word(input logic [2:0] idx);
      ident_word = (idx == 3'd0 || idx == 3'd3) ? Q_ONE : 32'sd0;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sh0_7FFF_FFFF) sat32 = 32'sh7FFF_FFFF;
      else if (v < -66'sh0_8000_0000) sat32 = 32'sh8000_0000;
      else sat32 = v[31:0];
   endfunction
endpackage

>>> design/ats_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on ats_pkg.
interface ats_req_if;
   import ats_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ats_rsp_if;
   import ats_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> design/ats_stack_mem.sv
// Coefficient stack memory: one write port, one registered read port.
// Depends on ats_pkg.
module ats_stack_mem (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ats_pkg::ADDR_W-1:0] wr_addr,
   input  logic signed [31:0]        wr_data,
   input  logic [ats_pkg::ADDR_W-1:0] rd_addr,
   output logic signed [31:0]        rd_data
);
   import ats_pkg::*;
   logic signed [31:0] mem [STACK_DEPTH*6];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

>>> design/ats_mac.sv
// Shared rounded Q multiplier with a registered product.
// Depends on ats_pkg.
module ats_mac (
   input  logic               clock,
   input  logic signed [31:0] op_x,
   input  logic signed [31:0] op_y,
   output logic signed [47:0] prod_ff
);
   import ats_pkg::*;
   logic signed [63:0] full;
   logic signed [63:0] rnd;
   logic signed [47:0] prod_in;

   always_comb begin
      full    = op_x * op_y;
      rnd     = full + (64'sd1 <<< (FRAC_BITS - 1));
      prod_in = 48'(rnd >>> FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule

>>> design/affine_transform_stack.sv
// Affine transform stack: stacked 2D matrices and their running product.
// Exit rebuilds the product from the remaining levels when the popped matrix was not
// identity; overflow and underflow go straight to the response.
// Items are taken one at a time; the next request can come with the response
// transfer; one shared 32x32 multiplier sets the pace.
// Reset (synchronous): level 0, product identity, viewport height 0; stack memory uncleared.
module affine_transform_stack (
   input  logic      clock,
   input  logic      reset,
   ats_req_if.sink   req,
   ats_rsp_if.source rsp,
   input  logic      csr_we,
   input  logic [31:0] csr_wdata
);
   import ats_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_WRITE = 4'd1;  // write six words to the stack
   localparam logic [3:0] S_CHK   = 4'd2;  // read popped entry, test identity
   localparam logic [3:0] S_RD    = 4'd3;  // read six words of one level
   localparam logic [3:0] S_MUL   = 4'd4;  // 12 products into temp
   localparam logic [3:0] S_MAP   = 4'd5;  // 4 products of the map
   localparam logic [3:0] S_OUT   = 4'd6;

   logic [3:0]         state_ff, state_in;
   logic [LVL_W-1:0]   level_ff, level_in;
   logic signed [31:0] prod_ff [6];
   logic signed [31:0] prod_in [6];
   logic signed [31:0] mat_ff [6];   // operand matrix (new set or a level)
   logic signed [31:0] mat_in [6];
   logic signed [65:0] acc_ff [6];
   logic signed [65:0] acc_in [6];
   logic signed [31:0] vh_ff;
   req_type            item_ff, item_in;
   logic [3:0]         cnt_ff, cnt_in;    // step within a phase
   logic [ENT_W-1:0]   row_ff, row_in;    // level being written, checked or folded in
   logic               nonid_ff, nonid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic signed [31:0] wr_data, rd_data;
   logic signed [31:0] mx, my;
   logic signed [47:0] mprod;
   logic signed [65:0] t4, t5;

   ats_stack_mem u_mem (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );
   ats_mac u_mac (.clock, .op_x(mx), .op_y(my), .prod_ff(mprod));

   assign req.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   // Multiplier operand schedule: step k feeds output term k/2, pair k%2.
   function automatic logic [2:0] p_idx(input logic [3:0] k);
      // term k: output t = k/2, pair j = k%2; p index = (t%2) + 2*j
      p_idx = 3'({1'b0, k[0], k[1]});
   endfunction
   function automatic logic [2:0] m_idx(input logic [3:0] k);
      // m index = 2*(t/2) + j
      m_idx = 3'({k[3:2], 1'b0} + {2'b0, k[0]});
   endfunction

   always_comb begin
      mx = prod_ff[p_idx(cnt_ff)];
      my = mat_ff[m_idx(cnt_ff)];
      if (state_ff == S_MAP) begin
         mx = prod_ff[{1'b0, cnt_ff[0], cnt_ff[1]}];
         my = cnt_ff[0] ? item_ff.point_y : item_ff.point_x;
      end
   end

   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      prod_in      = prod_ff;
      mat_in       = mat_ff;
      acc_in       = acc_ff;
      item_in      = item_ff;
      cnt_in       = cnt_ff;
      row_in       = row_ff;
      nonid_in     = nonid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_addr      = '0;
      t4           = '0;
      t5           = '0;

      case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               item_in = req.data;
               cnt_in  = '0;
               rsp_in  = '{mapped_x: '0, mapped_y: '0, point_valid: 1'b0,
                           error_code: ERR_NONE};
               for (int i = 0; i < 6; i++) acc_in[i] = '0;
               case (req.data.op)
                  OP_ENTER: begin
                     if (level_ff == LVL_W'(STACK_DEPTH)) begin
                        rsp_in.error_code = ERR_OVER;
                        state_in = S_OUT;
                     end else begin
                        row_in = level_ff[ENT_W-1:0];
                        for (int i = 0; i < 6; i++) mat_in[i] = ident_word(3'(i));
                        level_in = level_ff + 1'b1;
                        state_in = S_WRITE;
                     end
                  end
                  OP_EXIT: begin
                     if (level_ff == '0) begin
                        rsp_in.error_code = ERR_UNDER;
                        state_in = S_OUT;
                     end else begin
                        level_in = level_ff - 1'b1;
                        row_in   = ENT_W'(level_ff - 1'b1);
                        nonid_in = 1'b0;
                        state_in = S_CHK;
                     end
                  end
                  OP_SET: begin
                     mat_in = '{req.data.coef_a, req.data.coef_b, req.data.coef_c,
                                req.data.coef_d, req.data.coef_e, req.data.coef_f};
                     if (level_ff == '0) begin
                        level_in = LVL_W'(1);
                        row_in   = '0;
                     end else begin
                        row_in = ENT_W'(level_ff - 1'b1);
                     end
                     state_in = S_WRITE;
                  end
                  default: begin
                     state_in = S_MAP;
                  end
               endcase
            end
         end
         S_WRITE: begin
            // store one word per cycle; set then folds into the product
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(row_ff * 6 + cnt_ff);
            wr_data = mat_ff[cnt_ff[2:0]];
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == 4'd5) begin
               cnt_in   = '0;
               state_in = (item_ff.op == OP_SET) ? S_MUL : S_OUT;
            end
         end
         S_CHK: begin
            // cnt 0..5 issue reads, 1..6 check returned words
            if (cnt_ff != 4'd6) rd_addr = ADDR_W'(row_ff * 6 + cnt_ff);
            if (cnt_ff != 4'd0 && rd_data != ident_word(3'(cnt_ff - 1'b1)))
               nonid_in = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'd6) begin
               cnt_in = '0;
               row_in = '0;
               if (nonid_in) begin
                  for (int i = 0; i < 6; i++) prod_in[i] = ident_word(3'(i));
                  state_in = (level_ff == '0) ? S_OUT : S_RD;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_RD: begin
            if (cnt_ff != 4'd6) rd_addr = ADDR_W'(row_ff * 6 + cnt_ff);
            if (cnt_ff != 4'd0) mat_in[3'(cnt_ff - 1'b1)] = rd_data;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'd6) begin
               cnt_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // the product of step k is registered and lands in the following step
            if (cnt_ff != 4'd0)
               acc_in[3'((cnt_ff - 1'b1) >> 1)] =
                  acc_ff[3'((cnt_ff - 1'b1) >> 1)] + 66'(mprod);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'd12) begin
               t4 = acc_in[4] + 66'(prod_ff[4]);
               t5 = acc_in[5] + 66'(prod_ff[5]);
               for (int i = 0; i < 4; i++) prod_in[i] = sat32(acc_in[i]);
               prod_in[4] = sat32(t4);
               prod_in[5] = sat32(t5);
               for (int i = 0; i < 6; i++) acc_in[i] = '0;
               cnt_in = '0;
               if (item_ff.op == OP_SET ||
                   LVL_W'(row_ff) + 1'b1 == level_ff) begin
                  state_in = S_OUT;
               end else begin
                  row_in   = row_ff + 1'b1;
                  state_in = S_RD;
               end
            end
         end
         S_MAP: begin
            if (cnt_ff != 4'd0)
               acc_in[3'((cnt_ff - 1'b1) >> 1)] =
                  acc_ff[3'((cnt_ff - 1'b1) >> 1)] + 66'(mprod);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'd4) begin
               t4 = 66'(sat32(acc_in[0] + 66'(prod_ff[4])));
               t5 = 66'(sat32(acc_in[1] + 66'(prod_ff[5])));
               rsp_in.mapped_x    = t4[31:0];
               rsp_in.mapped_y    = sat32(66'(vh_ff) - t5);
               rsp_in.point_valid = 1'b1;
               cnt_in   = '0;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         vh_ff        <= '0;
         for (int i = 0; i < 6; i++) prod_ff[i] <= ident_word(3'(i));
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
         prod_ff      <= prod_in;
         if (csr_we) vh_ff <= csr_wdata;
      end
      mat_ff   <= mat_in;
      acc_ff   <= acc_in;
      item_ff  <= item_in;
      cnt_ff   <= cnt_in;
      row_ff   <= row_in;
      nonid_ff <= nonid_in;
      rsp_ff   <= rsp_in;
   end

   // Level never exceeds the stack depth.
   assert property (@(posedge clock) disable iff (reset)
      level_ff <= LVL_W'(STACK_DEPTH))
      else $error("stack level beyond depth");
   // A response is raised only from the output step.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff ##1 rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("response raised outside output step");
   // Memory writes happen only in the write state.
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == S_WRITE)
      else $error("stray stack write");
endmodule
